FILE: sv/aclr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aclr_pkg
// Types and constants shared by the artifact colour line renderer.
// ----------------------------------------------------------------------------
package aclr_pkg;

    localparam logic [1:0] OP_PAIR  = 2'd0;
    localparam logic [1:0] OP_EOL   = 2'd1;
    localparam logic [1:0] OP_VSYNC = 2'd2;

    localparam logic [1:0] MODE_TWO_BIT  = 2'd1;
    localparam logic [1:0] MODE_FIVE_BIT = 2'd2;

    localparam logic [2:0] REG_RENDER_MODE     = 3'd0;
    localparam logic [2:0] REG_PHASE_SELECT    = 3'd1;
    localparam logic [2:0] REG_VIEWPORT_LEFT   = 3'd2;
    localparam logic [2:0] REG_VIEWPORT_TOP    = 3'd3;
    localparam logic [2:0] REG_VIEWPORT_WIDTH  = 3'd4;
    localparam logic [2:0] REG_VIEWPORT_HEIGHT = 3'd5;

    localparam logic [4:0] SEED_ART_HIGH = 5'd14;
    localparam logic [2:0] RUN_FULL      = 3'd7;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] even_colour;
        logic [7:0] odd_colour;
        logic [1:0] even_class;
    } t_in_item;

    typedef struct packed {
        logic       pair_kind;
        logic [7:0] left_colour;
        logic [7:0] right_colour;
        logic [4:0] artifact_index;
        logic       artifact_phase;
        logic [8:0] pair_column;
        logic [8:0] row;
        logic       last_of_line;
    } t_out_item;

    typedef struct packed {
        logic [1:0] render_mode;
        logic [1:0] phase_select;
        logic [9:0] viewport_left;
        logic [8:0] viewport_top;
        logic [9:0] viewport_width;
        logic [8:0] viewport_height;
    } t_cfg;

    typedef struct packed {
        logic [1:0] cls;
        logic [7:0] odd_colour;
        logic [7:0] even_colour;
    } t_pixel;

    typedef struct packed {
        logic       new_line;
        logic       seed_cap;
        logic       seed_apply;
        logic       emit;
        logic       last;
        logic [8:0] column;
        logic [8:0] row;
        t_pixel     pix;
    } t_cmd;

endpackage

`default_nettype wire

FILE: sv/aclr_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aclr_front
// Accepts stream items, tracks line and column, classifies each pair
// against the viewport and queues commands for the back end.
// ----------------------------------------------------------------------------
module aclr_front #(
    parameter int MAX_LINE_PIXELS = 1024
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  aclr_pkg::t_cfg     i_cfg,
    input  wire                i_in_valid,
    input  aclr_pkg::t_in_item i_in_data,
    output logic               o_in_stall,
    input  wire                i_q_full,
    output logic               o_push,
    output aclr_pkg::t_cmd     o_cmd
);
    import aclr_pkg::*;

    localparam int PW = $clog2(MAX_LINE_PIXELS + 2);
    localparam int CW = ((PW > 11) ? PW : 11) + 1;

    logic [9:0]    r_line;
    logic [9:0]    n_line;
    logic [PW-1:0] r_pos;
    logic [PW-1:0] n_pos;

    logic          accept;
    logic [CW-1:0] pos_x;
    logic [CW-1:0] left_x;
    logic [CW-1:0] wf_x;
    logic [CW-1:0] col_x;
    logic [10:0]   top_x;
    logic [9:0]    row_diff;
    logic          in_v;
    logic          pos_ok;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    always_comb begin
        pos_x    = CW'(r_pos);
        left_x   = CW'({i_cfg.viewport_left[9:1], 1'b0});
        wf_x     = CW'({i_cfg.viewport_width[9:2], 2'b00});
        col_x    = (pos_x - CW'(4) - left_x) >> 1;
        top_x    = 11'(i_cfg.viewport_top);
        row_diff = r_line - 10'(i_cfg.viewport_top);
        in_v     = (11'(r_line) >= top_x) &&
                   (11'(r_line) < top_x + 11'(i_cfg.viewport_height));
        pos_ok   = pos_x < CW'(MAX_LINE_PIXELS);

        o_cmd                 = '0;
        o_cmd.pix.cls         = i_in_data.even_class;
        o_cmd.pix.odd_colour  = i_in_data.odd_colour;
        o_cmd.pix.even_colour = i_in_data.even_colour;
        o_cmd.row             = row_diff[8:0];
        o_cmd.column          = col_x[8:0];
        o_cmd.seed_cap        = (pos_x + CW'(6)) == left_x;
        o_cmd.seed_apply      = (pos_x + CW'(2)) == left_x;
        o_cmd.emit            = (pos_x >= left_x + CW'(4)) &&
                                (pos_x - CW'(4) < left_x + wf_x);
        o_cmd.last            = (pos_x - CW'(2)) == (left_x + wf_x);
        o_cmd.new_line        = 1'b0;

        n_line = r_line;
        n_pos  = r_pos;
        o_push = 1'b0;
        if (accept) begin
            case (i_in_data.opcode)
                OP_VSYNC: begin
                    n_line         = '0;
                    n_pos          = '0;
                    o_cmd.new_line = 1'b1;
                    o_push         = 1'b1;
                end
                OP_EOL: begin
                    if (r_line != 10'h3ff) begin
                        n_line = r_line + 10'd1;
                    end
                    n_pos          = '0;
                    o_cmd.new_line = 1'b1;
                    o_push         = 1'b1;
                end
                OP_PAIR: begin
                    if (pos_ok) begin
                        n_pos  = r_pos + PW'(2);
                        o_push = in_v;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line <= '0;
            r_pos  <= '0;
        end else begin
            r_line <= n_line;
            r_pos  <= n_pos;
        end
    end

endmodule

`default_nettype wire

FILE: sv/aclr_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aclr_queue
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module aclr_queue (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  aclr_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    input  wire            i_pop,
    output aclr_pkg::t_cmd o_cmd
);
    import aclr_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_count;
    logic [AW:0]   n_count;

    assign o_full  = r_count == (AW + 1)'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_mem[r_rd];

    always_comb begin
        n_count = r_count;
        if (i_push && !(i_pop && o_valid)) begin
            n_count = r_count + (AW + 1)'(1);
        end else if (!i_push && i_pop && o_valid) begin
            n_count = r_count - (AW + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (i_pop && o_valid) begin
                r_rd <= r_rd + AW'(1);
            end
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

FILE: sv/aclr_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aclr_back
// Runs the pair delay line, seed and artifact shift registers and drives
// the registered result channel.
// ----------------------------------------------------------------------------
module aclr_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  aclr_pkg::t_cfg      i_cfg,
    input  wire                 i_q_valid,
    input  aclr_pkg::t_cmd      i_cmd,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output aclr_pkg::t_out_item o_out_data
);
    import aclr_pkg::*;

    t_pixel    r_dly0;
    t_pixel    r_dly1;
    t_pixel    n_dly0;
    t_pixel    n_dly1;
    logic [1:0] r_seed;
    logic [1:0] n_seed;
    logic [2:0] r_run_bits;
    logic [2:0] n_run_bits;
    logic [4:0] r_artifact_bits;
    logic [4:0] n_artifact_bits;
    logic       r_out_valid;
    logic       n_out_valid;
    t_out_item  r_out;
    t_out_item  n_out;
    logic       base_phase;
    logic [1:0] mid_cl;
    logic [1:0] old_cl;

    assign o_pop       = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_dly0          = r_dly0;
        n_dly1          = r_dly1;
        n_seed          = r_seed;
        n_run_bits      = r_run_bits;
        n_artifact_bits = r_artifact_bits;
        n_out           = r_out;
        n_out_valid     = r_out_valid && i_out_stall;
        base_phase      = !i_cfg.phase_select[1];
        mid_cl          = r_dly0.cls;
        old_cl          = r_dly1.cls;

        if (o_pop) begin
            if (i_cmd.new_line) begin
                n_dly0          = '0;
                n_dly1          = '0;
                n_seed          = '0;
                n_run_bits      = '0;
                n_artifact_bits = '0;
            end else begin
                if (i_cmd.seed_cap) begin
                    n_seed = i_cmd.pix.cls;
                end
                if (i_cmd.seed_apply) begin
                    if (r_seed != 2'd0 && i_cmd.pix.cls != 2'd0) begin
                        n_run_bits      = RUN_FULL;
                        n_artifact_bits = (r_seed[0] ? SEED_ART_HIGH : 5'd0) |
                                          {4'd0, i_cmd.pix.cls[0]};
                    end else begin
                        n_run_bits      = '0;
                        n_artifact_bits = '0;
                    end
                end
                if (i_cmd.emit) begin
                    n_out                = '0;
                    n_out.pair_column    = i_cmd.column;
                    n_out.row            = i_cmd.row;
                    n_out.last_of_line   = i_cmd.last;
                    case (i_cfg.render_mode)
                        MODE_TWO_BIT: begin
                            if (!i_cmd.column[0]) begin
                                if (old_cl != 2'd0 && mid_cl != 2'd0) begin
                                    n_run_bits      = RUN_FULL;
                                    n_artifact_bits = {3'd0, old_cl[0], mid_cl[0]};
                                end else begin
                                    n_run_bits      = '0;
                                    n_artifact_bits = '0;
                                end
                            end
                            if (n_run_bits == RUN_FULL) begin
                                n_out.pair_kind      = 1'b1;
                                n_out.artifact_index = {3'd0, n_artifact_bits[1:0]};
                                n_out.artifact_phase = base_phase;
                            end
                        end
                        MODE_FIVE_BIT: begin
                            n_run_bits      = {r_run_bits[1:0], mid_cl[1]};
                            n_artifact_bits = {r_artifact_bits[3:0], i_cmd.pix.cls[0]};
                            if (n_run_bits == RUN_FULL) begin
                                n_out.pair_kind      = 1'b1;
                                n_out.artifact_index = n_artifact_bits;
                                n_out.artifact_phase = base_phase ^ i_cmd.column[0];
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (!n_out.pair_kind) begin
                        n_out.left_colour  = r_dly1.even_colour;
                        n_out.right_colour = r_dly1.odd_colour;
                    end
                    n_out_valid = 1'b1;
                end
                n_dly1 = r_dly0;
                n_dly0 = i_cmd.pix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dly0          <= '0;
            r_dly1          <= '0;
            r_seed          <= '0;
            r_run_bits      <= '0;
            r_artifact_bits <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_dly0          <= n_dly0;
            r_dly1          <= n_dly1;
            r_seed          <= n_seed;
            r_run_bits      <= n_run_bits;
            r_artifact_bits <= n_artifact_bits;
            r_out_valid     <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

FILE: sv/artifact_colour_line_renderer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// artifact_colour_line_renderer_core
// Results: the result for a pair is built when the pair two pairs after it
// is popped from the command queue, and is then held in the result register.
// Throughput: one item per cycle while the queue is not full; a 4-entry queue decouples input from output.
// Reset: synchronous, active low; registers return to their defaults and the
// line, column, shift and delay state clears.
// ----------------------------------------------------------------------------
module artifact_colour_line_renderer_core #(
    parameter int MAX_LINE_PIXELS = 1024
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire  [2:0]          i_cfg_index,
    input  wire  [9:0]          i_cfg_data,
    input  wire                 i_in_valid,
    input  aclr_pkg::t_in_item  i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output aclr_pkg::t_out_item o_out_data
);
    import aclr_pkg::*;

    t_cfg r_cfg;
    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;
    t_cmd push_cmd;
    t_cmd pop_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.render_mode     <= 2'd0;
            r_cfg.phase_select    <= 2'd0;
            r_cfg.viewport_left   <= 10'd190;
            r_cfg.viewport_top    <= 9'd14;
            r_cfg.viewport_width  <= 10'd640;
            r_cfg.viewport_height <= 9'd240;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_RENDER_MODE:     r_cfg.render_mode     <= i_cfg_data[1:0];
                REG_PHASE_SELECT:    r_cfg.phase_select    <= i_cfg_data[1:0];
                REG_VIEWPORT_LEFT:   r_cfg.viewport_left   <= i_cfg_data;
                REG_VIEWPORT_TOP:    r_cfg.viewport_top    <= i_cfg_data[8:0];
                REG_VIEWPORT_WIDTH:  r_cfg.viewport_width  <= i_cfg_data;
                REG_VIEWPORT_HEIGHT: r_cfg.viewport_height <= i_cfg_data[8:0];
                default: begin
                end
            endcase
        end
    end

    aclr_front #(
        .MAX_LINE_PIXELS (MAX_LINE_PIXELS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_cmd      (push_cmd)
    );

    aclr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (pop_cmd)
    );

    aclr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_cmd       (pop_cmd),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

FILE: verif/tb_artifact_colour_line_renderer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_artifact_colour_line_renderer_core
// Self-checking bench for the artifact colour line renderer. A short table of
// hand-picked pairs runs first. Then come a tall frame that runs the line
// counter into saturation, one overlong line, and random frames under random
// register settings. Every accepted item goes through a local line model.
// Results are compared field by field with the oldest outstanding prediction
// while both handshakes idle in random bursts.
// ----------------------------------------------------------------------------
module tb_artifact_colour_line_renderer_core;
    import aclr_pkg::*;

    localparam int PERIOD          = 10;
    localparam int MAX_LINE_PIXELS = 1024;
    localparam int LINE_COUNT_MAX  = 1023;
    localparam int ITEM_BUDGET     = 750;
    localparam int DRAIN_CYCLES    = 16;
    localparam int CYCLE_LIMIT     = 400000;

    localparam logic [1:0] MODE_PASS  = 2'd0;
    localparam logic [1:0] MODE_UNDEF = 2'd3;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    localparam logic [1:0] CLS_OTHER = 2'd0;
    localparam logic [1:0] CLS_ODD   = 2'd1;
    localparam logic [1:0] CLS_BLACK = 2'd2;
    localparam logic [1:0] CLS_WHITE = 2'd3;

    localparam t_cfg RESET_CFG = '{MODE_PASS, 2'd0, 10'd190, 9'd14, 10'd640, 9'd240};

    typedef struct {
        bit        is_setting;
        t_cfg      setting;
        t_in_item  item;
        bit        fixed;
        t_out_item want;
    } t_stim_row;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [9:0] cfg_data = '0;
    logic       in_valid = 1'b0;
    t_in_item   in_data = '0;
    logic       in_stall;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out_item  out_data;

    // line model state
    t_cfg       settings;
    int         line_count;
    int         col_pos;
    logic [2:0] run_bits;
    logic [4:0] art_bits;
    logic [1:0] seed_cls;
    t_pixel     pair_hist [2];

    t_out_item  pair_results [$];
    t_stim_row  directed_rows [$];

    int errors = 0;
    int items_sent = 0;
    int cycle_count = 0;
    int stall_left = 0;
    bit quiet = 1'b0;
    bit in_gaps = 1'b1;
    bit out_gaps = 1'b1;

    artifact_colour_line_renderer_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #(PERIOD / 2) clk = ~clk;

    function automatic void start_line();
        col_pos = 0;
        run_bits = '0;
        art_bits = '0;
        seed_cls = '0;
        pair_hist[0] = '0;
        pair_hist[1] = '0;
    endfunction

    function automatic bit render_item(input t_in_item it, output t_out_item res);
        int         pos, lft, wid, top, hgt, x, j;
        t_pixel     old;
        logic [1:0] mid_cl;
        logic       p;
        bit         hit;
        hit = 1'b0;
        res = '0;
        case (it.opcode)
            OP_VSYNC: begin
                line_count = 0;
                start_line();
            end
            OP_EOL: begin
                if (line_count < LINE_COUNT_MAX) line_count++;
                start_line();
            end
            OP_PAIR: begin
                pos = col_pos;
                lft = int'(settings.viewport_left) & ~1;
                wid = int'(settings.viewport_width) & ~3;
                top = int'(settings.viewport_top);
                hgt = int'(settings.viewport_height);
                if (pos < MAX_LINE_PIXELS) begin
                    if (line_count >= top && line_count < top + hgt) begin
                        if (pos + 6 == lft) seed_cls = it.even_class;
                        if (pos + 2 == lft) begin
                            if (seed_cls != CLS_OTHER && it.even_class != CLS_OTHER) begin
                                run_bits = RUN_FULL;
                                art_bits = (seed_cls[0] ? SEED_ART_HIGH : 5'd0)
                                           | {4'd0, it.even_class[0]};
                            end else begin
                                run_bits = '0;
                                art_bits = '0;
                            end
                        end
                        if (pos >= lft + 4 && pos - 4 < lft + wid) begin
                            x = pos - 4;
                            j = (x - lft) >> 1;
                            old = pair_hist[1];
                            mid_cl = pair_hist[0].cls;
                            p = ~settings.phase_select[1];
                            if (settings.render_mode == MODE_TWO_BIT) begin
                                // first pair of a four-pixel group decides for both
                                if (!j[0]) begin
                                    if (old.cls != CLS_OTHER && mid_cl != CLS_OTHER) begin
                                        run_bits = RUN_FULL;
                                        art_bits = {3'd0, old.cls[0], mid_cl[0]};
                                    end else begin
                                        run_bits = '0;
                                        art_bits = '0;
                                    end
                                end
                                if (run_bits == RUN_FULL) begin
                                    res.pair_kind = 1'b1;
                                    res.artifact_index = {3'd0, art_bits[1:0]};
                                    res.artifact_phase = p;
                                end
                            end else if (settings.render_mode == MODE_FIVE_BIT) begin
                                run_bits = {run_bits[1:0], mid_cl[1]};
                                art_bits = {art_bits[3:0], it.even_class[0]};
                                if (run_bits == RUN_FULL) begin
                                    res.pair_kind = 1'b1;
                                    res.artifact_index = art_bits;
                                    res.artifact_phase = p ^ j[0];
                                end
                            end
                            if (!res.pair_kind) begin
                                res.left_colour = old.even_colour;
                                res.right_colour = old.odd_colour;
                            end
                            res.pair_column = 9'(j);
                            res.row = 9'(line_count - top);
                            res.last_of_line = (x + 2 == lft + wid);
                            hit = 1'b1;
                        end
                    end
                    pair_hist[1] = pair_hist[0];
                    pair_hist[0] = '{it.even_class, it.odd_colour, it.even_colour};
                    col_pos = pos + 2;
                end
            end
            default: ;
        endcase
        return hit;
    endfunction

    task automatic add_setting(input t_cfg c);
        directed_rows.push_back('{1'b1, c, '0, 1'b0, '0});
    endtask

    task automatic add_item(input logic [1:0] op, input logic [7:0] ec, input logic [7:0] oc,
                            input logic [1:0] cl, input bit fixed = 1'b0,
                            input t_out_item want = '0);
        directed_rows.push_back('{1'b0, RESET_CFG, t_in_item'{op, ec, oc, cl}, fixed, want});
    endtask

    task automatic send_item(input t_in_item it, input bit fixed, input t_out_item want);
        t_out_item r;
        if (!quiet && in_gaps && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (in_stall !== 1'b0);
        items_sent++;
        if (render_item(it, r)) pair_results.push_back(fixed ? want : r);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [9:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic apply_config(input t_cfg c);
        in_valid <= 1'b0;
        while (pair_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_reg(REG_RENDER_MODE, 10'(c.render_mode));
        write_reg(REG_PHASE_SELECT, 10'(c.phase_select));
        write_reg(REG_VIEWPORT_LEFT, c.viewport_left);
        write_reg(REG_VIEWPORT_TOP, 10'(c.viewport_top));
        write_reg(REG_VIEWPORT_WIDTH, c.viewport_width);
        write_reg(REG_VIEWPORT_HEIGHT, 10'(c.viewport_height));
        cfg_we <= 1'b0;
        settings = c;
    endtask

    task automatic send_line(input int pairs, input bit noisy);
        t_in_item it;
        int       r;
        for (int k = 0; k < pairs; k++) begin
            if (noisy && $urandom_range(0, 15) == 0) begin
                it.opcode = ($urandom_range(0, 3) == 0) ? OP_VSYNC : OP_UNUSED;
                it.even_colour = 8'($urandom);
                it.odd_colour = 8'($urandom);
                it.even_class = 2'($urandom);
                send_item(it, 1'b0, '0);
            end
            it.opcode = OP_PAIR;
            it.even_colour = ($urandom_range(0, 7) == 0) ? {8{1'($urandom)}} : 8'($urandom);
            it.odd_colour = ($urandom_range(0, 7) == 0) ? {8{1'($urandom)}} : 8'($urandom);
            r = $urandom_range(0, 9);
            it.even_class = (r < 2) ? CLS_OTHER : (r < 3) ? CLS_ODD : (r < 6) ? CLS_BLACK
                                                                             : CLS_WHITE;
            send_item(it, 1'b0, '0);
        end
        it.opcode = OP_EOL;
        it.even_colour = 8'($urandom);
        it.odd_colour = 8'($urandom);
        it.even_class = 2'($urandom);
        send_item(it, 1'b0, '0);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // output side stall bursts
    always @(posedge clk) begin
        if ($urandom_range(0, 63) == 0) out_gaps <= ~out_gaps;
        if (quiet || !rst_n) begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (out_gaps && $urandom_range(0, 5) == 0) begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 4);
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin : result_check
        t_out_item want;
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            if (pair_results.size() == 0) begin
                errors++;
                $display("%0t ns: expected no transfer, actual %p", $time, out_data);
            end else begin
                want = pair_results.pop_front();
                check_field("pair_kind", int'(want.pair_kind), int'(out_data.pair_kind));
                check_field("left_colour", int'(want.left_colour), int'(out_data.left_colour));
                check_field("right_colour", int'(want.right_colour),
                            int'(out_data.right_colour));
                check_field("artifact_index", int'(want.artifact_index),
                            int'(out_data.artifact_index));
                check_field("artifact_phase", int'(want.artifact_phase),
                            int'(out_data.artifact_phase));
                check_field("pair_column", int'(want.pair_column), int'(out_data.pair_column));
                check_field("row", int'(want.row), int'(out_data.row));
                check_field("last_of_line", int'(want.last_of_line),
                            int'(out_data.last_of_line));
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        t_cfg     c;
        t_in_item it;
        int       lines, span, pairs, r;

        settings = RESET_CFG;
        line_count = 0;
        start_line();

        // pass-through, viewport at columns 6..13 of lines 0 and 1
        add_setting('{MODE_PASS, 2'd0, 10'd6, 9'd0, 10'd8, 9'd2});
        add_item(OP_PAIR, 8'h00, 8'hff, CLS_WHITE);
        add_item(OP_PAIR, 8'h12, 8'h34, CLS_OTHER);
        add_item(OP_PAIR, 8'h56, 8'h78, CLS_BLACK);
        add_item(OP_PAIR, 8'hff, 8'h00, CLS_WHITE);
        add_item(OP_PAIR, 8'h00, 8'hff, CLS_ODD);
        add_item(OP_PAIR, 8'h5a, 8'ha5, CLS_BLACK, 1'b1,
                 '{1'b0, 8'hff, 8'h00, 5'd0, 1'b0, 9'd0, 9'd0, 1'b0});
        add_item(OP_PAIR, 8'h81, 8'h7e, CLS_WHITE, 1'b1,
                 '{1'b0, 8'h00, 8'hff, 5'd0, 1'b0, 9'd1, 9'd0, 1'b0});
        add_item(OP_PAIR, 8'hc3, 8'h3c, CLS_OTHER);
        add_item(OP_PAIR, 8'hff, 8'hff, CLS_WHITE);
        add_item(OP_UNUSED, 8'hff, 8'hff, CLS_WHITE);
        add_item(OP_EOL, 8'h00, 8'h00, CLS_OTHER);
        // five-bit mode on line 1, all black and white
        add_setting('{MODE_FIVE_BIT, 2'd3, 10'd6, 9'd0, 10'd8, 9'd2});
        add_item(OP_PAIR, 8'h01, 8'h02, CLS_WHITE);
        add_item(OP_PAIR, 8'h03, 8'h04, CLS_BLACK);
        add_item(OP_PAIR, 8'h05, 8'h06, CLS_WHITE);
        add_item(OP_PAIR, 8'h07, 8'h08, CLS_WHITE);
        add_item(OP_PAIR, 8'h09, 8'h0a, CLS_BLACK);
        add_item(OP_PAIR, 8'h0b, 8'h0c, CLS_WHITE);
        add_item(OP_PAIR, 8'h0d, 8'h0e, CLS_BLACK);
        add_item(OP_PAIR, 8'h0f, 8'h10, CLS_BLACK);
        add_item(OP_PAIR, 8'h11, 8'h12, CLS_WHITE);
        add_item(OP_EOL, 8'hff, 8'hff, CLS_WHITE);
        // line 2 lies below the viewport
        add_item(OP_PAIR, 8'haa, 8'h55, CLS_WHITE);
        add_item(OP_PAIR, 8'h55, 8'haa, CLS_BLACK);
        add_item(OP_VSYNC, 8'h00, 8'h00, CLS_OTHER);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[n]) begin
            if (directed_rows[n].is_setting)
                apply_config(directed_rows[n].setting);
            else
                send_item(directed_rows[n].item, directed_rows[n].fixed, directed_rows[n].want);
        end

        // tall frame: bottom rows and line counter saturation
        c = '{MODE_FIVE_BIT, 2'd1, 10'd6, 9'd511, 10'd8, 9'd511};
        apply_config(c);
        it = '{OP_VSYNC, 8'h00, 8'h00, CLS_OTHER};
        send_item(it, 1'b0, '0);
        it.opcode = OP_EOL;
        repeat (511) send_item(it, 1'b0, '0);
        send_line(8, 1'b0);
        repeat (509) send_item(it, 1'b0, '0);
        send_line(8, 1'b0);
        send_line(8, 1'b0);
        repeat (4) send_item(it, 1'b0, '0);
        c = '{MODE_PASS, 2'd0, 10'd6, 9'd0, 10'd8, 9'd511};
        apply_config(c);
        send_line(8, 1'b0);

        // overlong line across a viewport 1016 pixels wide
        c = '{($urandom_range(0, 1) != 0) ? MODE_TWO_BIT : MODE_FIVE_BIT,
              2'($urandom), 10'd6, 9'd0, 10'd1016, 9'd1};
        apply_config(c);
        it = '{OP_VSYNC, 8'hff, 8'hff, CLS_WHITE};
        send_item(it, 1'b0, '0);
        send_line(520, 1'b0);

        items_sent = 0;
        while (items_sent < ITEM_BUDGET) begin
            r = $urandom_range(0, 9);
            c.render_mode = (r < 3) ? MODE_TWO_BIT : (r < 6) ? MODE_FIVE_BIT
                          : (r < 9) ? MODE_PASS : MODE_UNDEF;
            c.phase_select = 2'($urandom);
            case ($urandom_range(0, 9))
                0: c.viewport_left = 10'($urandom_range(0, 5));
                1: c.viewport_left = 10'($urandom_range(1016, 1023));
                default: c.viewport_left = 10'($urandom_range(6, 24));
            endcase
            case ($urandom_range(0, 9))
                0: c.viewport_width = 10'($urandom_range(0, 3));
                1: c.viewport_width = ($urandom_range(0, 1) != 0) ? 10'd1016 : 10'd1023;
                default: c.viewport_width = 10'($urandom_range(4, 40));
            endcase
            c.viewport_top = 9'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0: c.viewport_height = 9'd0;
                1: c.viewport_height = 9'd511;
                default: c.viewport_height = 9'($urandom_range(1, 3));
            endcase
            apply_config(c);

            it.opcode = ($urandom_range(0, 4) != 0) ? OP_VSYNC : OP_EOL;
            it.even_colour = 8'($urandom);
            it.odd_colour = 8'($urandom);
            it.even_class = 2'($urandom);
            send_item(it, 1'b0, '0);

            lines = int'(c.viewport_top) + 1
                  + ((c.viewport_height > 9'd2) ? 2 : int'(c.viewport_height));
            span = (int'(c.viewport_left) & ~1) + (int'(c.viewport_width) & ~3);
            for (int l = 0; l < lines; l++) begin
                pairs = span / 2 + $urandom_range(0, 3);
                if (pairs > 64) pairs = 48 + $urandom_range(0, 16);
                if ($urandom_range(0, 7) == 0) pairs = $urandom_range(0, pairs);
                in_gaps = ($urandom_range(0, 3) != 0);
                send_line(pairs, 1'b1);
                if (items_sent >= ITEM_BUDGET - 120) quiet = 1'b1;
            end
        end

        in_valid <= 1'b0;
        while (pair_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: artifact_colour_line_renderer_core.f
sv/aclr_pkg.sv
sv/aclr_front.sv
sv/aclr_queue.sv
sv/aclr_back.sv
sv/artifact_colour_line_renderer_core.sv
verif/tb_artifact_colour_line_renderer_core.sv
